FILE: src/xxtea_pkg.sv
// Shared constants, types and the control store for the XXTEA block encryptor.
package xxtea_pkg;

   localparam int unsigned MAX_WORDS = 8;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned KEY_WORDS = 4;
   localparam int unsigned IDX_W     = $clog2(MAX_WORDS);
   localparam int unsigned N_W       = $clog2(MAX_WORDS + 1);
   localparam int unsigned BW_W      = 4;
   localparam int unsigned CMP_W     = (N_W > BW_W) ? N_W : BW_W;
   localparam int unsigned ROUND_W   = 6;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned STEP_W    = 4;

   localparam logic [WORD_W-1:0] DELTA = 32'h9e3779b9;
   localparam logic [BW_W-1:0] BLOCK_WORDS_RESET = BW_W'(MAX_WORDS);

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [KEY_WORDS-1:0] key_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [N_W-1:0] count_type;
   typedef logic [ROUND_W-1:0] rounds_type;

   // register map
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_KEY0        = 3'd0;
   localparam csr_idx_type CSR_KEY1        = 3'd1;
   localparam csr_idx_type CSR_KEY2        = 3'd2;
   localparam csr_idx_type CSR_KEY3        = 3'd3;
   localparam csr_idx_type CSR_BLOCK_WORDS = 3'd4;

   // control store addresses
   typedef logic [STEP_W-1:0] step_type;
   localparam step_type STEP_LOAD  = 4'd0;
   localparam step_type STEP_INIT  = 4'd1;
   localparam step_type STEP_WAIT  = 4'd2;
   localparam step_type STEP_PREV  = 4'd3;
   localparam step_type STEP_ROUND = 4'd4;
   localparam step_type STEP_READ  = 4'd5;
   localparam step_type STEP_MIX   = 4'd6;
   localparam step_type STEP_WRITE = 4'd7;
   localparam step_type STEP_RCHK  = 4'd8;
   localparam step_type STEP_ERD   = 4'd9;
   localparam step_type STEP_EMIT  = 4'd10;

   typedef enum logic [1:0] {SUM_HOLD, SUM_CLEAR, SUM_ADD} sum_op_type;
   typedef enum logic [1:0] {RND_HOLD, RND_LOAD, RND_DEC} rounds_op_type;
   typedef enum logic [1:0] {P_HOLD, P_ZERO, P_LAST, P_INC} p_op_type;
   typedef enum logic [1:0] {PREV_HOLD, PREV_RDATA, PREV_NEW} prev_op_type;
   typedef enum logic [2:0] {
      JMP_NEXT, JMP_LOAD, JMP_NOT_LAST, JMP_ROUNDS, JMP_EMIT
   } jump_type;

   typedef struct packed {
      logic          in_ready;
      logic          load_en;
      logic          rsp_valid;
      sum_op_type    sum_op;
      rounds_op_type rounds_op;
      p_op_type      p_op;
      prev_op_type   prev_op;
      logic          mx_load;
      logic          upd_write;
      jump_type      jump;
      step_type      target;
   } ucode_word_type;

   typedef struct packed {
      logic          load_en;
      sum_op_type    sum_op;
      rounds_op_type rounds_op;
      p_op_type      p_op;
      prev_op_type   prev_op;
      logic          mx_load;
      logic          upd_write;
   } dp_ctl_type;

   typedef struct packed {
      logic full;
      logic p_last;
      logic rounds_zero;
   } dp_status_type;

   localparam ucode_word_type UCODE_NOP = '{
      in_ready:  1'b0,
      load_en:   1'b0,
      rsp_valid: 1'b0,
      sum_op:    SUM_HOLD,
      rounds_op: RND_HOLD,
      p_op:      P_HOLD,
      prev_op:   PREV_HOLD,
      mx_load:   1'b0,
      upd_write: 1'b0,
      jump:      JMP_NEXT,
      target:    STEP_LOAD
   };

   function automatic ucode_word_type ucode_rom(input step_type step);
      ucode_word_type w;
      w = UCODE_NOP;
      case (step)
         STEP_LOAD: begin
            w.in_ready = 1'b1;
            w.load_en  = 1'b1;
            w.jump     = JMP_LOAD;
            w.target   = STEP_INIT;
         end
         STEP_INIT: begin
            w.sum_op    = SUM_CLEAR;
            w.rounds_op = RND_LOAD;
            w.p_op      = P_LAST;
         end
         STEP_WAIT: begin
            w.jump = JMP_NEXT;
         end
         STEP_PREV: begin
            w.prev_op = PREV_RDATA;
         end
         STEP_ROUND: begin
            w.sum_op    = SUM_ADD;
            w.rounds_op = RND_DEC;
            w.p_op      = P_ZERO;
         end
         STEP_READ: begin
            w.jump = JMP_NEXT;
         end
         STEP_MIX: begin
            w.mx_load = 1'b1;
         end
         STEP_WRITE: begin
            w.upd_write = 1'b1;
            w.prev_op   = PREV_NEW;
            w.p_op      = P_INC;
            w.jump      = JMP_NOT_LAST;
            w.target    = STEP_READ;
         end
         STEP_RCHK: begin
            w.p_op   = P_ZERO;
            w.jump   = JMP_ROUNDS;
            w.target = STEP_ROUND;
         end
         STEP_ERD: begin
            w.jump = JMP_NEXT;
         end
         STEP_EMIT: begin
            w.rsp_valid = 1'b1;
            w.p_op      = P_INC;
            w.jump      = JMP_EMIT;
            w.target    = STEP_ERD;
         end
         default: begin
            w.jump   = JMP_LOAD;
            w.target = STEP_LOAD;
         end
      endcase
      return w;
   endfunction

   // 6 + 52/n
   function automatic rounds_type rounds_for(input count_type n);
      rounds_type r;
      case (n) inside
         1:        r = 6'd58;
         2:        r = 6'd32;
         3:        r = 6'd23;
         4:        r = 6'd19;
         5:        r = 6'd16;
         6:        r = 6'd14;
         7:        r = 6'd13;
         8:        r = 6'd12;
         [9:10]:   r = 6'd11;
         [11:13]:  r = 6'd10;
         [14:17]:  r = 6'd9;
         [18:26]:  r = 6'd8;
         [27:52]:  r = 6'd7;
         default:  r = 6'd6;
      endcase
      return r;
   endfunction

endpackage

FILE: src/xxtea_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module xxtea_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

FILE: src/xxtea_datapath.sv
// Datapath: word store, round registers and the MX mixing unit.
module xxtea_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  xxtea_pkg::dp_ctl_type     ctl,
   output xxtea_pkg::dp_status_type  status,
   input  xxtea_pkg::key_type        key,
   input  logic [xxtea_pkg::BW_W-1:0] block_words,
   input  xxtea_pkg::word_type       plain_word,
   output xxtea_pkg::word_type       cipher_word
);

   xxtea_pkg::count_type  n;
   logic [xxtea_pkg::CMP_W-1:0] n_cmp;
   xxtea_pkg::idx_type    last_idx;
   xxtea_pkg::idx_type    next_idx;
   xxtea_pkg::count_type  count_inc;
   logic                  full;

   xxtea_pkg::idx_type    count_ff, count_in;
   xxtea_pkg::idx_type    p_ff, p_in;
   xxtea_pkg::word_type   sum_ff, sum_in;
   xxtea_pkg::rounds_type rounds_ff, rounds_in;
   xxtea_pkg::word_type   prev_ff, prev_in;
   xxtea_pkg::word_type   mx_ff, mx_in;

   xxtea_pkg::word_type   rdata_a, rdata_b;
   xxtea_pkg::word_type   new_word;
   logic [1:0]            kidx;

   logic                  wr_en;
   xxtea_pkg::idx_type    wr_addr;
   xxtea_pkg::word_type   wr_data;

   // effective block size: 0 acts as 1, above capacity clamps
   always_comb begin
      n_cmp = xxtea_pkg::CMP_W'(block_words);
      if (n_cmp == '0) begin
         n_cmp = xxtea_pkg::CMP_W'(1);
      end else if (n_cmp > xxtea_pkg::CMP_W'(xxtea_pkg::MAX_WORDS)) begin
         n_cmp = xxtea_pkg::CMP_W'(xxtea_pkg::MAX_WORDS);
      end
      n = xxtea_pkg::N_W'(n_cmp);
   end

   assign last_idx  = xxtea_pkg::IDX_W'(n - xxtea_pkg::N_W'(1));
   assign next_idx  = (p_ff == last_idx) ? '0 : p_ff + xxtea_pkg::IDX_W'(1);
   assign count_inc = xxtea_pkg::N_W'(count_ff) + xxtea_pkg::N_W'(1);
   assign full      = (count_inc >= n);

   assign status.full        = full;
   assign status.p_last      = (p_ff == last_idx);
   assign status.rounds_zero = (rounds_ff == '0);

   // MX: z is the previous word, y the right neighbor
   assign kidx  = xxtea_pkg::IDX_W >= 2 ? 2'(p_ff) ^ sum_ff[3:2] : 2'(p_ff) ^ sum_ff[3:2];
   assign mx_in = (((prev_ff >> 5) ^ (rdata_b << 2)) + ((rdata_b >> 3) ^ (prev_ff << 4)))
                  ^ ((sum_ff ^ rdata_b) + (key[kidx] ^ prev_ff));
   assign new_word = rdata_a + mx_ff;

   always_comb begin
      count_in = count_ff;
      if (ctl.load_en) begin
         count_in = full ? '0 : xxtea_pkg::IDX_W'(count_inc);
      end
   end

   always_comb begin
      case (ctl.p_op)
         xxtea_pkg::P_ZERO: p_in = '0;
         xxtea_pkg::P_LAST: p_in = last_idx;
         xxtea_pkg::P_INC:  p_in = p_ff + xxtea_pkg::IDX_W'(1);
         default:           p_in = p_ff;
      endcase
   end

   always_comb begin
      case (ctl.sum_op)
         xxtea_pkg::SUM_CLEAR: sum_in = '0;
         xxtea_pkg::SUM_ADD:   sum_in = sum_ff + xxtea_pkg::DELTA;
         default:              sum_in = sum_ff;
      endcase
   end

   always_comb begin
      case (ctl.rounds_op)
         xxtea_pkg::RND_LOAD: rounds_in = xxtea_pkg::rounds_for(n);
         xxtea_pkg::RND_DEC:  rounds_in = rounds_ff - xxtea_pkg::ROUND_W'(1);
         default:             rounds_in = rounds_ff;
      endcase
   end

   always_comb begin
      case (ctl.prev_op)
         xxtea_pkg::PREV_RDATA: prev_in = rdata_a;
         xxtea_pkg::PREV_NEW:   prev_in = new_word;
         default:               prev_in = prev_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         p_ff      <= '0;
         sum_ff    <= '0;
         rounds_ff <= '0;
         prev_ff   <= '0;
      end else begin
         count_ff  <= count_in;
         p_ff      <= p_in;
         sum_ff    <= sum_in;
         rounds_ff <= rounds_in;
         prev_ff   <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      mx_ff <= ctl.mx_load ? mx_in : mx_ff;
   end

   assign wr_en   = ctl.load_en | ctl.upd_write;
   assign wr_addr = ctl.load_en ? count_ff : p_ff;
   assign wr_data = ctl.load_en ? plain_word : new_word;

   xxtea_ram #(
      .WIDTH (xxtea_pkg::WORD_W),
      .DEPTH (xxtea_pkg::MAX_WORDS)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (p_ff),
      .rd_addr_b (next_idx),
      .rd_data_a (rdata_a),
      .rd_data_b (rdata_b)
   );

   assign cipher_word = rdata_a;

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      ctl.upd_write |-> !ctl.load_en)
      else $error("load and update write in the same cycle");

   a_no_round_underflow: assert property (@(posedge clock) disable iff (reset)
      ctl.rounds_op == xxtea_pkg::RND_DEC |-> rounds_ff != '0)
      else $error("round counter decremented at zero");

   a_mix_before_write: assert property (@(posedge clock) disable iff (reset)
      ctl.upd_write |-> $past(ctl.mx_load))
      else $error("word written back without a fresh mix");

endmodule

FILE: src/xxtea_ucode_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
module xxtea_ucode_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  xxtea_pkg::dp_status_type  status,
   output xxtea_pkg::dp_ctl_type     ctl
);

   xxtea_pkg::step_type       step_ff, step_in;
   xxtea_pkg::ucode_word_type uword;
   logic                      in_xfer;
   logic                      out_xfer;

   assign uword    = xxtea_pkg::ucode_rom(step_ff);
   assign in_xfer  = req_valid & uword.in_ready;
   assign out_xfer = uword.rsp_valid & rsp_ready;

   // next step
   always_comb begin
      case (uword.jump)
         xxtea_pkg::JMP_LOAD:
            step_in = (in_xfer && status.full) ? uword.target : step_ff;
         xxtea_pkg::JMP_NOT_LAST:
            step_in = !status.p_last ? uword.target : step_ff + xxtea_pkg::STEP_W'(1);
         xxtea_pkg::JMP_ROUNDS:
            step_in = !status.rounds_zero ? uword.target
                                          : step_ff + xxtea_pkg::STEP_W'(1);
         xxtea_pkg::JMP_EMIT: begin
            if (!out_xfer) begin
               step_in = step_ff;
            end else begin
               step_in = status.p_last ? xxtea_pkg::STEP_LOAD : uword.target;
            end
         end
         default:
            step_in = step_ff + xxtea_pkg::STEP_W'(1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= xxtea_pkg::STEP_LOAD;
      end else begin
         step_ff <= step_in;
      end
   end

   // outputs; strobes that wait on a transfer are qualified here
   always_comb begin
      req_ready     = uword.in_ready;
      rsp_valid     = uword.rsp_valid;
      ctl.load_en   = uword.load_en & in_xfer;
      ctl.sum_op    = uword.sum_op;
      ctl.rounds_op = uword.rounds_op;
      ctl.p_op      = (uword.jump == xxtea_pkg::JMP_EMIT && !out_xfer) ? xxtea_pkg::P_HOLD
                                                                       : uword.p_op;
      ctl.prev_op   = uword.prev_op;
      ctl.mx_load   = uword.mx_load;
      ctl.upd_write = uword.upd_write;
   end

   a_full_starts_block: assert property (@(posedge clock) disable iff (reset)
      (in_xfer && status.full) |=> step_ff == xxtea_pkg::STEP_INIT)
      else $error("completed block did not start encryption");

   a_one_side_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("loading and emitting at once");

endmodule

FILE: src/xxtea_block_encrypt.sv
// Top level of the XXTEA block encryptor: register file and core instances.
//
// Usage: plaintext words enter on req_plain_word with req_valid/req_ready,
// one transfer per cycle while loading. The csr port sets the 128-bit key
// (indexes 0..3) and the block size (index 4, 0 acts as 1, values above 8
// act as 8); write it only while the block is idle.
// Once the last word of a block is taken, req_ready drops and the core
// runs 6 + 52/n rounds, each round a sum step, then read, mix and write
// back steps per word, then a check step, all on a single MX unit and
// one two-read-port word store. Then the n ciphertext words leave on
// rsp_cipher_word, rsp_last_word marking the final one, each read from
// the store, then presented; no new block is taken until the last leaves.
// A stalled receiver holds the current word and freezes the sequencer.
// Reset (synchronous) clears the keys, sets the block size to 8 and drops
// any partly loaded block.
module xxtea_block_encrypt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [31:0]                     req_plain_word,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [31:0]                     rsp_cipher_word,
   output logic                            rsp_last_word,
   input  logic                            csr_wr_en,
   input  logic [xxtea_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                     csr_wdata
);

   xxtea_pkg::key_type        key_ff, key_in;
   logic [xxtea_pkg::BW_W-1:0] block_words_ff, block_words_in;
   xxtea_pkg::dp_ctl_type     ctl;
   xxtea_pkg::dp_status_type  status;

   always_comb begin
      key_in         = key_ff;
      block_words_in = block_words_ff;
      if (csr_wr_en) begin
         case (csr_index)
            xxtea_pkg::CSR_KEY0:        key_in[0] = csr_wdata;
            xxtea_pkg::CSR_KEY1:        key_in[1] = csr_wdata;
            xxtea_pkg::CSR_KEY2:        key_in[2] = csr_wdata;
            xxtea_pkg::CSR_KEY3:        key_in[3] = csr_wdata;
            xxtea_pkg::CSR_BLOCK_WORDS: block_words_in = csr_wdata[xxtea_pkg::BW_W-1:0];
            default:                    key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff         <= '0;
         block_words_ff <= xxtea_pkg::BLOCK_WORDS_RESET;
      end else begin
         key_ff         <= key_in;
         block_words_ff <= block_words_in;
      end
   end

   xxtea_ucode_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .ctl       (ctl)
   );

   xxtea_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .status      (status),
      .key         (key_ff),
      .block_words (block_words_ff),
      .plain_word  (req_plain_word),
      .cipher_word (rsp_cipher_word)
   );

   assign rsp_last_word = status.p_last;

endmodule
